[rtl/pat_pkg.sv]
// Shared types and constants of the pending acknowledgement tracker.
`default_nettype none
package pat_pkg;

   localparam int SLOTS = 16;

   localparam int OP_W   = 2;
   localparam int KIND_W = 8;
   localparam int BOOT_W = 16;
   localparam int SEQ_W  = 32;
   localparam int TIME_W = 32;

   // Operation codes of an input transfer; code 3 is unused and ignored.
   typedef enum logic [OP_W-1:0] {
      OP_SENT  = 2'd0,
      OP_ACK   = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   // One table entry as it moves from cell to cell.
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BOOT_W-1:0] boot;
      logic [SEQ_W-1:0]  seq;
      logic [TIME_W-1:0] sent_time;
   } entry_type;

   // Per-cycle command broadcast to every cell.
   typedef struct packed {
      logic shift;
      logic ack;
      logic clr;
   } cell_ctl_type;

   // Search results rippling from the oldest cell toward the newest.
   typedef struct packed {
      logic              hit;
      logic [KIND_W-1:0] hit_kind;
      logic              rpt;
      logic [TIME_W-1:0] rpt_time;
   } chain_type;

endpackage
`default_nettype wire

[rtl/pat_cell.sv]
// One table cell: holds a single entry and joins the match and report search chains.
`default_nettype none
module pat_cell (
   input  wire                           clock,
   input  wire                           reset,
   input  wire pat_pkg::cell_ctl_type    ctl,
   input  wire  [pat_pkg::KIND_W-1:0]    code,
   input  wire  [pat_pkg::BOOT_W-1:0]    key_boot,
   input  wire  [pat_pkg::SEQ_W-1:0]     key_seq,
   input  wire pat_pkg::entry_type       up_entry,
   input  wire                           up_valid,
   input  wire pat_pkg::chain_type       older_chain,
   output pat_pkg::entry_type            entry,
   output logic                          valid,
   output pat_pkg::chain_type            newer_chain
);

   pat_pkg::entry_type entry_ff;
   pat_pkg::entry_type entry_in;
   logic               valid_ff;
   logic               valid_in;
   logic               my_hit;
   logic               my_rpt;

   assign my_hit = valid_ff && (entry_ff.boot == key_boot) && (entry_ff.seq == key_seq);
   assign my_rpt = valid_ff && (entry_ff.kind == code);

   // The older side wins, so the chain carries the oldest hit toward cell 0.
   always_comb begin
      newer_chain.hit      = older_chain.hit | my_hit;
      newer_chain.hit_kind = older_chain.hit ? older_chain.hit_kind :
                             (my_hit ? entry_ff.kind : '0);
      newer_chain.rpt      = older_chain.rpt | my_rpt;
      newer_chain.rpt_time = older_chain.rpt ? older_chain.rpt_time :
                             (my_rpt ? entry_ff.sent_time : '0);
   end

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      priority if (ctl.clr) begin
         valid_in = 1'b0;
      end else if (ctl.shift) begin
         entry_in = up_entry;
         valid_in = up_valid;
      end else if (ctl.ack) begin
         // An acknowledged entry takes every older one with it. Only cells newer
         // than the oldest match see a hit on their older side, so only they stay.
         valid_in = valid_ff & older_chain.hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign valid = valid_ff;

endmodule
`default_nettype wire

[rtl/pending_ack_tracker.sv]
// Top level of the pending acknowledgement tracker: table cells, result and output stages.
//
// The tracker keeps up to SLOTS sent packets that wait for an acknowledgement, newest
// in cell 0 and oldest at the far end of the chain. A transfer on the req_ channel is
// taken at a clock edge where req_valid is high and req_stall is low. A sent operation
// shifts every entry one cell older and writes the new one into cell 0; the entry in
// the last cell falls off, which drops the oldest packet when the table is full. An
// ack operation finds the oldest matching entry and invalidates it together with all
// older entries. A clear operation invalidates every cell.
// Each input transfer gives exactly one rsp_ transfer with the matched type and the
// age of the oldest pending report. The result passes through the result stage and
// then the output register. Without stalls one item per cycle is sustained, since the
// table update finishes in the cycle the input is taken; the match search that ripples
// along the cell chain sets that path. The report age is found in the result stage
// from the updated cells.
// When the receiver stalls, the result register holds and the result stage fills;
// req_stall then rises until the receiver takes the waiting result.
// Reset empties the table, clears both stages and sets the report type code to 1.
// csr_write_enable writes the report type code. Write it only while idle; nothing enforces it.
`default_nettype none
module pending_ack_tracker (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_stall,
   input  wire  [pat_pkg::OP_W-1:0]      req_operation,
   input  wire  [pat_pkg::KIND_W-1:0]    req_packet_type,
   input  wire  [pat_pkg::BOOT_W-1:0]    req_boot_id,
   input  wire  [pat_pkg::SEQ_W-1:0]     req_seq_number,
   input  wire  [pat_pkg::TIME_W-1:0]    req_now_time,
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output logic [pat_pkg::KIND_W-1:0]    rsp_matched_type,
   output logic [pat_pkg::TIME_W-1:0]    rsp_report_age,
   input  wire                           csr_write_enable,
   input  wire  [pat_pkg::KIND_W-1:0]    csr_write_data
);

   localparam int SLOTS = pat_pkg::SLOTS;

   // Configuration register.
   logic [pat_pkg::KIND_W-1:0] code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff <= pat_pkg::KIND_W'(1);
      end else if (csr_write_enable) begin
         code_ff <= csr_write_data;
      end
   end

   // Search results along the cell chain; element SLOTS enters at the oldest end with nothing found.
   pat_pkg::chain_type chain      [SLOTS+1];

   // Input transfer and the command it gives the cells.
   logic                  req_fire;
   pat_pkg::op_type       op;
   pat_pkg::cell_ctl_type ctl;
   pat_pkg::entry_type    new_entry;

   assign req_fire = req_valid && !req_stall;
   assign op       = pat_pkg::op_type'(req_operation);

   // An ack is only passed to the cells when some entry matched, so an ack that
   // misses leaves the table as it is.
   always_comb begin
      ctl = '0;
      if (req_fire) begin
         unique case (op)
            pat_pkg::OP_SENT:  ctl.shift = 1'b1;
            pat_pkg::OP_ACK:   ctl.ack   = chain[0].hit;
            pat_pkg::OP_CLEAR: ctl.clr   = 1'b1;
            default:           ctl       = '0;
         endcase
      end
   end

   always_comb begin
      new_entry.kind      = req_packet_type;
      new_entry.boot      = req_boot_id;
      new_entry.seq       = req_seq_number;
      new_entry.sent_time = req_now_time;
   end

   // The cell chain. Entries move toward higher indexes; search results move toward
   // cell 0, entering at the oldest end with nothing found.
   pat_pkg::entry_type cell_entry [SLOTS];
   logic               cell_valid [SLOTS];

   assign chain[SLOTS] = '0;

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      pat_pkg::entry_type up_entry;
      logic               up_valid;

      if (i == 0) begin : g_head
         assign up_entry = new_entry;
         assign up_valid = 1'b1;
      end else begin : g_body
         assign up_entry = cell_entry[i-1];
         assign up_valid = cell_valid[i-1];
      end

      pat_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .code        (code_ff),
         .key_boot    (req_boot_id),
         .key_seq     (req_seq_number),
         .up_entry    (up_entry),
         .up_valid    (up_valid),
         .older_chain (chain[i+1]),
         .entry       (cell_entry[i]),
         .valid       (cell_valid[i]),
         .newer_chain (chain[i])
      );
   end

   // Result stage: holds the matched type and the time of the accepted item. The
   // report search runs here over cells that already show the item's update.
   logic                       p_valid_ff;
   logic                       p_valid_in;
   logic [pat_pkg::KIND_W-1:0] p_matched_ff;
   logic [pat_pkg::TIME_W-1:0] p_now_ff;
   logic                       p_move;
   logic [pat_pkg::TIME_W-1:0] age;

   assign p_move    = !rsp_valid || !rsp_stall;
   assign req_stall = p_valid_ff && !p_move;
   assign age       = chain[0].rpt ? (p_now_ff - chain[0].rpt_time) : '0;

   always_comb begin
      priority if (req_fire) begin
         p_valid_in = 1'b1;
      end else if (p_move) begin
         p_valid_in = 1'b0;
      end else begin
         p_valid_in = p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= p_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         p_matched_ff <= ctl.ack ? chain[0].hit_kind : '0;
         p_now_ff     <= req_now_time;
      end
   end

   // Output register.
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic [pat_pkg::KIND_W-1:0] rsp_matched_ff;
   logic [pat_pkg::TIME_W-1:0] rsp_age_ff;

   always_comb begin
      priority if (p_valid_ff && p_move) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (p_valid_ff && p_move) begin
         rsp_matched_ff <= p_matched_ff;
         rsp_age_ff     <= age;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_matched_type = rsp_matched_ff;
   assign rsp_report_age   = rsp_age_ff;

endmodule
`default_nettype wire
